FILE: hdl/mac_pair_encounter_tracker_defines.svh
// Assertion macros for the encounter tracker
`ifndef MAC_PAIR_ENCOUNTER_TRACKER_DEFINES_SVH
`define MAC_PAIR_ENCOUNTER_TRACKER_DEFINES_SVH
// implication checked every clock outside reset
`define MPET_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("label failed");
// next-cycle implication
`define MPET_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("label failed");
`endif

FILE: hdl/mpet_pkg.sv
// Package: types and constants of the encounter tracker
`default_nettype none
package mpet_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] GAP_RESET = 32'd1800;
  localparam logic [1:0] OK_RECORD = 2'd0;
  localparam logic [1:0] OK_DONE = 2'd1;
  localparam logic [1:0] OK_DROP = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [31:0] ts;
    logic        ap;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] a;
    logic [47:0] b;
    logic [31:0] s;
    logic [31:0] e;
    logic        ap;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EVAL, ST_FLUSH_RD, ST_DONE
  } eng_state_t;
endpackage
`default_nettype wire

FILE: hdl/mpet_front.sv
// Front end: input queue that decouples acceptance from table work
`default_nettype none
module mpet_front import mpet_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  wire  q_take,
  output cmd_t q_cmd
);
  cmd_t     buf_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) buf_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_take && q_valid);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/mpet_engine.sv
// Back end: pair table, match, update, flush walk and result register
`default_nettype none
`include "mac_pair_encounter_tracker_defines.svh"
module mpet_engine import mpet_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [31:0] gap,
  input  wire         q_valid,
  output logic        q_take,
  input  cmd_t        q_cmd,
  output logic        res_valid,
  input  wire         res_ready,
  output res_t        res
);
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [47:0] ka_r [TABLE_DEPTH];
  logic [47:0] kb_r [TABLE_DEPTH];
  logic [31:0] st_r [TABLE_DEPTH];
  logic [31:0] en_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] apf_r;

  eng_state_t state_r, state_nxt;
  cmd_t       cmd_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic       hit_r, free_ok_r;
  logic [IDX_W-1:0] hidx_r, fidx_r;
  logic [31:0] hs_r, he_r;
  logic        hap_r;
  logic        res_valid_r;
  res_t        res_r;
  logic        emit_c;

  // match vectors (combinational); hit, free slot and entry fields are registered in ST_READ
  logic [TABLE_DEPTH-1:0] dir_m, rev_m;
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      dir_m[i] = vld_r[i] && ka_r[i] == cmd_r.a1 && kb_r[i] == cmd_r.a2;
      rev_m[i] = vld_r[i] && ka_r[i] == cmd_r.a2 && kb_r[i] == cmd_r.a1;
    end
  end

  logic             any_d, any_r, any_f;
  logic [IDX_W-1:0] id_d, id_r, id_f;
  always_comb begin
    any_d = 1'b0; any_r = 1'b0; any_f = 1'b0;
    id_d = '0; id_r = '0; id_f = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (dir_m[i]) begin any_d = 1'b1; id_d = IDX_W'(i); end
      if (rev_m[i]) begin any_r = 1'b1; id_r = IDX_W'(i); end
      if (!vld_r[i]) begin any_f = 1'b1; id_f = IDX_W'(i); end
    end
  end

  logic out_free;
  assign out_free = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res = res_r;

  logic [31:0] diff;
  logic        close_c, fq_c;
  assign diff    = cmd_r.ts - he_r;
  assign close_c = he_r != 32'd0 && cmd_r.ts >= he_r && diff >= gap;
  assign fq_c    = vld_r[idx_r] && st_r[idx_r] != en_r[idx_r] && en_r[idx_r] != 32'd0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (q_valid) state_nxt = q_cmd.kind ? ST_FLUSH_RD : ST_READ;
      ST_READ:     state_nxt = ST_EVAL;
      ST_EVAL:     if (out_free) state_nxt = ST_IDLE;
      ST_FLUSH_RD: if (out_free && idx_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take  = (state_r == ST_IDLE) && q_valid;
    idx_nxt = idx_r;
    if (state_r == ST_IDLE) idx_nxt = '0;
    else if (state_r == ST_FLUSH_RD && out_free) idx_nxt = idx_r + IDX_W'(1);
    emit_c = 1'b0;
    unique case (state_r)
      ST_EVAL:     emit_c = out_free &&
                            (hit_r ? (close_c && hs_r != he_r) : !free_ok_r);
      ST_FLUSH_RD: emit_c = out_free && fq_c;
      ST_DONE:     emit_c = out_free;
      default:     emit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; vld_r <= '0; res_valid_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      res_valid_r <= emit_c || (res_valid_r && !res_ready);
      unique case (state_r)
        ST_EVAL: if (out_free && !hit_r && free_ok_r) vld_r[fidx_r] <= 1'b1;
        ST_FLUSH_RD: if (out_free) vld_r[idx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) cmd_r <= q_cmd;
    if (state_r == ST_READ) begin
      hit_r <= any_d || any_r;
      hidx_r <= any_d ? id_d : id_r;
      free_ok_r <= any_f;
      fidx_r <= id_f;
      hs_r  <= st_r[any_d ? id_d : id_r];
      he_r  <= en_r[any_d ? id_d : id_r];
      hap_r <= apf_r[any_d ? id_d : id_r];
    end
    unique case (state_r)
      ST_EVAL: if (out_free) begin
        if (!hit_r) begin
          if (free_ok_r) begin
            ka_r[fidx_r] <= cmd_r.a1; kb_r[fidx_r] <= cmd_r.a2;
            st_r[fidx_r] <= cmd_r.ts; en_r[fidx_r] <= 32'd0;
            apf_r[fidx_r] <= cmd_r.ap;
          end else
            res_r <= '{OK_DROP, cmd_r.a1, cmd_r.a2, cmd_r.ts, 32'd0, cmd_r.ap, 1'b1};
        end else begin
          if (close_c) begin
            st_r[hidx_r] <= cmd_r.ts;
            res_r <= '{OK_RECORD, cmd_r.a1, cmd_r.a2, hs_r, he_r, hap_r, 1'b1};
          end
          en_r[hidx_r]  <= cmd_r.ts;
          apf_r[hidx_r] <= hap_r | cmd_r.ap;
        end
      end
      ST_FLUSH_RD: if (out_free && fq_c)
        res_r <= '{OK_RECORD, ka_r[idx_r], kb_r[idx_r], st_r[idx_r], en_r[idx_r],
                   apf_r[idx_r], 1'b0};
      ST_DONE: if (out_free)
        res_r <= '{OK_DONE, 48'd0, 48'd0, 32'd0, 32'd0, 1'b0, 1'b1};
      default: ;
    endcase
  end

  `MPET_ASSERT_NXT(a_flush_clears, state_r == ST_DONE, vld_r == '0)
  `MPET_ASSERT_IMP(a_take_idle, q_take, state_r == ST_IDLE)
  `MPET_ASSERT_NXT(a_res_hold, res_valid_r && !res_ready, res_valid_r && $stable(res_r))
endmodule
`default_nettype wire

FILE: hdl/mac_pair_encounter_tracker.sv
// Top level of the address-pair encounter tracker
// Usage:
//  in_* channel (valid/ready) carries one word per packet or flush.
//  out_* channel (valid/ready) returns result words; last_of_run marks
//  the final result of an input word. cfg_* writes gap_seconds.
//  A packet holds the table engine for its dequeue, parallel key
//  compare over all 32 entries and update steps; the engine takes the
//  next word only once that update is done.
//  A flush walks the table one entry a cycle while the output register
//  is free, then gives the done marker; records go out one a cycle
//  while out_ready stays high.
//  A two-word input queue takes new words while the engine works.
//  The update step and each walk step wait while the output register
//  holds an unaccepted word; the queue keeps filling, then in_ready drops.
//  Reset (rst_n low, synchronous) empties the table and queue and
//  loads gap_seconds with 1800. Config only while idle.
`default_nettype none
module mac_pair_encounter_tracker import mpet_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_kind,
  input  wire  [47:0] in_addr_one,
  input  wire  [47:0] in_addr_two,
  input  wire  [31:0] in_time_sec,
  input  wire         in_toward_ap,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_pair_first,
  output logic [47:0] out_pair_second,
  output logic [31:0] out_start_sec,
  output logic [31:0] out_end_sec,
  output logic        out_ap_flag,
  output logic        out_last_of_run,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data
);
  logic [31:0] gap_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;
  res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= GAP_RESET;
    else if (cfg_valid) gap_r <= cfg_data;
  end

  assign in_cmd = '{in_kind, in_addr_one, in_addr_two, in_time_sec, in_toward_ap};

  mpet_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_take, .q_cmd
  );

  mpet_engine u_engine (
    .clk, .rst_n, .gap(gap_r), .q_valid, .q_take, .q_cmd,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_kind        = res.kind;
  assign out_pair_first  = res.a;
  assign out_pair_second = res.b;
  assign out_start_sec   = res.s;
  assign out_end_sec     = res.e;
  assign out_ap_flag     = res.ap;
  assign out_last_of_run = res.last;
endmodule
`default_nettype wire

FILE: dv/tb_mac_pair_encounter_tracker.sv
// Testbench for the address-pair encounter tracker: random and directed packets and flushes
`timescale 1ns / 1ps
`default_nettype none
module tb_mac_pair_encounter_tracker;
  import mpet_pkg::*;

  class encounter_scoreboard;
    logic        tbl_valid[TABLE_DEPTH];
    logic [47:0] tbl_a[TABLE_DEPTH];
    logic [47:0] tbl_b[TABLE_DEPTH];
    logic [31:0] tbl_s[TABLE_DEPTH];
    logic [31:0] tbl_e[TABLE_DEPTH];
    logic        tbl_ap[TABLE_DEPTH];
    logic [31:0] gap;
    res_t        pending[$];
    int          errors;
    int          n_checked;
    int          n_drops;
    int          n_records;

    function new();
      gap = GAP_RESET;
      errors = 0;
      n_checked = 0;
      n_drops = 0;
      n_records = 0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    endfunction

    function void push(logic [1:0] k, logic [47:0] a, logic [47:0] b,
                       logic [31:0] s, logic [31:0] e, logic ap, logic last);
      res_t r;
      r.kind = k; r.a = a; r.b = b; r.s = s; r.e = e; r.ap = ap; r.last = last;
      pending.push_back(r);
    endfunction

    function void note_word(cmd_t c);
      int hit, rev, free_idx;
      hit = -1; rev = -1; free_idx = -1;
      if (c.kind) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_s[i] != tbl_e[i] && tbl_e[i] != 0)
            push(OK_RECORD, tbl_a[i], tbl_b[i], tbl_s[i], tbl_e[i], tbl_ap[i], 1'b0);
          tbl_valid[i] = 1'b0;
        end
        push(OK_DONE, '0, '0, '0, '0, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i]) begin
          if (hit < 0 && tbl_a[i] == c.a1 && tbl_b[i] == c.a2) hit = i;
          if (rev < 0 && tbl_a[i] == c.a2 && tbl_b[i] == c.a1) rev = i;
        end else if (free_idx < 0) free_idx = i;
      end
      if (hit < 0) hit = rev;
      if (hit < 0) begin
        if (free_idx < 0) begin
          push(OK_DROP, c.a1, c.a2, c.ts, '0, c.ap, 1'b1);
          return;
        end
        tbl_valid[free_idx] = 1'b1;
        tbl_a[free_idx] = c.a1; tbl_b[free_idx] = c.a2;
        tbl_s[free_idx] = c.ts; tbl_e[free_idx] = '0; tbl_ap[free_idx] = c.ap;
        return;
      end
      if (tbl_e[hit] != 0 && c.ts >= tbl_e[hit] && (c.ts - tbl_e[hit]) >= gap) begin
        if (tbl_s[hit] != tbl_e[hit])
          push(OK_RECORD, c.a1, c.a2, tbl_s[hit], tbl_e[hit], tbl_ap[hit], 1'b1);
        tbl_s[hit] = c.ts;
      end
      tbl_e[hit] = c.ts;
      tbl_ap[hit] = tbl_ap[hit] | c.ap;
    endfunction

    function void check_word(res_t got);
      res_t w;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word kind=%0d", got.kind);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.kind == OK_DROP) n_drops++;
      if (got.kind == OK_RECORD) n_records++;
      if (got.kind !== w.kind) begin
        $error("out_kind exp %0d got %0d", w.kind, got.kind); errors++; end
      if (got.a !== w.a) begin
        $error("pair_first exp %h got %h", w.a, got.a); errors++; end
      if (got.b !== w.b) begin
        $error("pair_second exp %h got %h", w.b, got.b); errors++; end
      if (got.s !== w.s) begin
        $error("start_sec exp %0d got %0d", w.s, got.s); errors++; end
      if (got.e !== w.e) begin
        $error("end_sec exp %0d got %0d", w.e, got.e); errors++; end
      if (got.ap !== w.ap) begin
        $error("ap_flag exp %0d got %0d", w.ap, got.ap); errors++; end
      if (got.last !== w.last) begin
        $error("last_of_run exp %0d got %0d", w.last, got.last); errors++; end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [47:0] in_addr_one = '0;
  logic [47:0] in_addr_two = '0;
  logic [31:0] in_time_sec = '0;
  logic in_toward_ap = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [47:0] out_pair_first, out_pair_second;
  logic [31:0] out_start_sec, out_end_sec;
  logic out_ap_flag, out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  encounter_scoreboard sb = new();
  int cycle_count = 0;
  int words_sent = 0;
  bit drain_stalls = 1'b1;
  logic [47:0] addr_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mac_pair_encounter_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_addr_one(in_addr_one), .in_addr_two(in_addr_two),
    .in_time_sec(in_time_sec), .in_toward_ap(in_toward_ap),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_pair_first(out_pair_first), .out_pair_second(out_pair_second),
    .out_start_sec(out_start_sec), .out_end_sec(out_end_sec),
    .out_ap_flag(out_ap_flag), .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_mac_pair_encounter_tracker: done, errors");
      $finish;
    end
  end

  // result side: random stall per word, ready drops only while stalling
  initial begin : result_sink
    int stall;
    res_t r;
    @(posedge clk iff rst_n);
    forever begin
      stall = (drain_stalls && $urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      r.kind = out_kind; r.a = out_pair_first; r.b = out_pair_second;
      r.s = out_start_sec; r.e = out_end_sec; r.ap = out_ap_flag;
      r.last = out_last_of_run;
      sb.check_word(r);
    end
  end

  // valid stays up into the next word when no idle cycles are drawn
  task automatic send_word(cmd_t c, bit idle_gaps);
    int gap_cycles;
    gap_cycles = idle_gaps ? $urandom_range(0, 7) : 0;
    if (gap_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= c.kind;
    in_addr_one <= c.a1;
    in_addr_two <= c.a2;
    in_time_sec <= c.ts;
    in_toward_ap <= c.ap;
    @(posedge clk iff in_ready);
    sb.note_word(c);
    words_sent++;
  endtask

  task automatic send_pkt(logic [47:0] a1, logic [47:0] a2, logic [31:0] ts, logic ap);
    cmd_t c;
    c.kind = 1'b0; c.a1 = a1; c.a2 = a2; c.ts = ts; c.ap = ap;
    send_word(c, 1'b1);
  endtask

  task automatic send_flush();
    cmd_t c;
    c = '0;
    c.kind = 1'b1;
    c.a1 = 48'({$urandom, $urandom});
    c.a2 = 48'({$urandom, $urandom});
    c.ts = $urandom;
    c.ap = 1'($urandom_range(0, 1));
    send_word(c, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // settle, then write gap_seconds while the block is idle
  task automatic write_gap(logic [31:0] val);
    wait_drained();
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    sb.gap = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n_words, int n_addrs, int max_step);
    logic [31:0] now;
    int x, y;
    now = $urandom_range(1, 1000);
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_flush();
      end else begin
        x = $urandom_range(0, n_addrs - 1);
        y = $urandom_range(0, n_addrs - 1);
        // time mostly advances, sometimes steps back
        if ($urandom_range(0, 9) == 0) now = now - $urandom_range(0, max_step);
        else now = now + $urandom_range(0, max_step);
        if ($urandom_range(0, 19) == 0)
          send_pkt(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
                   1'($urandom_range(0, 1)));
        else
          send_pkt(addr_pool[x], addr_pool[y], now, 1'($urandom_range(0, 1)));
      end
    end
    send_flush();
  endtask

  initial begin
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default gap, reversed match, close with and without record
    send_pkt(addr_pool[0], addr_pool[1], 32'd0, 1'b0);
    send_pkt(addr_pool[1], addr_pool[0], 32'd100, 1'b1);
    send_pkt(addr_pool[0], addr_pool[1], 32'd1900, 1'b0);
    send_pkt(addr_pool[0], addr_pool[1], 32'd3800, 1'b0);
    send_pkt(addr_pool[1], addr_pool[0], 32'd5700, 1'b0);
    send_pkt(addr_pool[2], addr_pool[3], 32'hFFFF_FFFF, 1'b1);
    send_pkt(addr_pool[3], addr_pool[2], 32'd5, 1'b0);
    send_pkt(addr_pool[2], addr_pool[3], 32'hFFFF_FFFF, 1'b0);
    send_pkt(addr_pool[4], addr_pool[4], 32'd7, 1'b0);
    send_flush();
    // fill the table past capacity to hit drops
    for (int i = 0; i < TABLE_DEPTH + 3; i++)
      send_pkt(48'(i + 1), 48'(i + 1000), 32'(i), i[0]);
    send_pkt(48'd1, 48'd1000, 32'd50, 1'b1);
    send_flush();

    write_gap(32'd1);
    send_pkt(addr_pool[5], addr_pool[6], 32'd10, 1'b0);
    send_pkt(addr_pool[5], addr_pool[6], 32'd11, 1'b1);
    send_pkt(addr_pool[6], addr_pool[5], 32'd12, 1'b0);
    send_flush();

    random_phase(40, 6, 3);
    write_gap(32'hFFFF_FFFF);
    random_phase(30, 8, 1 << 30);
    write_gap(32'd20);
    drain_stalls = 1'b0;
    random_phase(40, 8, 15);
    drain_stalls = 1'b1;
    write_gap(GAP_RESET);
    random_phase(40, 8, 900);

    wait_drained();
    repeat (60) @(posedge clk);
    $display("covered %0d input words, %0d result words (%0d records, %0d drops)",
             words_sent, sb.n_checked, sb.n_records, sb.n_drops);
    $display("gap settings 1800, 1, max, 20; reversed pairs, table overflow, flushes");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_mac_pair_encounter_tracker: done, clean");
    else
      $display("tb_mac_pair_encounter_tracker: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
